[design/pls_pkg.sv]
// Shared constants, types and codes for the positional list store.
// No dependencies; imported by pls_unit, positional_list_store and the bench.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

   // list capacity and derived widths
   localparam int DEPTH = 8;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry index
   localparam int CW    = $clog2(DEPTH + 1);                  // length count
   localparam int CMP_W = ((CW > 8) ? CW : 8) + 1;            // position compare

   // command codes
   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_INSERT = 2'd3;

   typedef logic [IW-1:0] idx_type;
   typedef logic [CW-1:0] cnt_type;
   typedef logic [31:0]   word_type;

   // operands of the shared step/compare unit
   typedef struct packed {
      idx_type  idx;
      idx_type  stop;
      logic     down;
      word_type data;
      word_type key;
   } unit_in_type;

   // results of the shared step/compare unit
   typedef struct packed {
      idx_type nxt;
      logic    at_stop;
      logic    match;
   } unit_out_type;

endpackage

`default_nettype wire

[design/pls_unit.sv]
// Shared step and compare unit: next index up or down, end-of-walk check,
// and key match against the entry just read. Depends on pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_unit
   import pls_pkg::*;
(
   input  wire unit_in_type  unit_in,
   output unit_out_type      unit_out
);

   always_comb begin
      unit_out.nxt     = unit_in.down ? (unit_in.idx - idx_type'(1))
                                      : (unit_in.idx + idx_type'(1));
      unit_out.at_stop = (unit_in.idx == unit_in.stop);
      unit_out.match   = (unit_in.data == unit_in.key);
   end

endmodule

`default_nettype wire

[design/positional_list_store.sv]
// Top level of the positional list store: command sequencer, entry memory
// and response registers. Depends on pls_pkg and pls_unit.
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Ports                                                  | Handshake
// -----------+--------------------------------------------------------+-------------------------
// command    | start, req_command, req_position, req_value            | beat when start && !busy
// response   | rsp_valid, rsp_status, rsp_data_out,                   | one-cycle strobe,
//            | rsp_found_position, rsp_list_length                    | no back-pressure
//
// One command is handled at a time; busy stays high until its response is
// registered. Every step goes through the single read port of the entry
// memory and the one shared step/compare unit. A get reads and captures one
// entry; a find reads and compares entries from the first one up; a delete
// captures the entry, then moves each later entry down one slot; an insert
// moves entries up one slot from the end to the target, then writes the value.
// The response shows in the first cycle that busy is low again; for a
// rejected command, in the cycle after the beat. Reset (synchronous)
// empties the list; entry contents are not cleared. The response side
// cannot stall, so a beat is never held.

module positional_list_store
   import pls_pkg::*;
(
   input  wire              clock,
   input  wire              reset,

   input  wire              start,
   output logic             busy,
   input  wire  [1:0]       req_command,
   input  wire  [7:0]       req_position,
   input  wire  [31:0]      req_value,

   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [31:0]      rsp_data_out,
   output logic [3:0]       rsp_found_position,
   output logic [3:0]       rsp_list_length
);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_GET_RD   = 4'd1;
   localparam logic [3:0] S_GET_CAP  = 4'd2;
   localparam logic [3:0] S_FIND_RD  = 4'd3;
   localparam logic [3:0] S_FIND_CMP = 4'd4;
   localparam logic [3:0] S_DEL_RD   = 4'd5;
   localparam logic [3:0] S_DEL_CAP  = 4'd6;
   localparam logic [3:0] S_MV_RD    = 4'd7;
   localparam logic [3:0] S_MV_WR    = 4'd8;

   // control state
   logic [3:0] state_ff, state_in;
   cnt_type    count_ff, count_in;
   logic       rsp_valid_ff;

   // working registers of the command in flight
   idx_type    idx_ff,  idx_in;
   idx_type    stop_ff, stop_in;
   logic       down_ff, down_in;
   word_type   key_ff,  key_in;
   word_type   hold_ff, hold_in;

   // response payload
   logic       rsp_status_ff;
   word_type   rsp_data_out_ff;
   logic [3:0] rsp_found_position_ff;
   logic [3:0] rsp_list_length_ff;

   // entry memory: one write port, one registered read port
   word_type   mem [DEPTH];
   word_type   rd_data_ff;
   idx_type    rd_addr;
   logic       wr_en;
   idx_type    wr_addr;
   word_type   wr_data;

   // completion
   logic       fin;
   logic       fin_status;
   word_type   fin_data;
   logic [3:0] fin_found;

   // request decode
   logic       pos_nonzero;
   logic       pos_in_list;
   logic       pos_in_ins;
   logic       list_full;
   idx_type    pos_idx;
   idx_type    last_idx;

   unit_in_type  unit_in;
   unit_out_type unit_out;

   pls_unit u_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   assign unit_in.idx  = idx_ff;
   assign unit_in.stop = stop_ff;
   assign unit_in.down = down_ff;
   assign unit_in.data = rd_data_ff;
   assign unit_in.key  = key_ff;

   // position checks against the current length
   assign pos_nonzero = (req_position != 8'd0);
   assign pos_in_list = (CMP_W'(req_position) <= CMP_W'(count_ff));
   assign pos_in_ins  = (CMP_W'(req_position) <= (CMP_W'(count_ff) + CMP_W'(1)));
   assign list_full   = (count_ff >= cnt_type'(DEPTH));
   assign pos_idx     = IW'(req_position - 8'd1);
   assign last_idx    = IW'(count_ff - cnt_type'(1));

   // during a shift walk, read the source entry ahead of the write
   assign rd_addr = (state_ff == S_MV_RD) ? unit_out.nxt : idx_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      stop_in    = stop_ff;
      down_in    = down_ff;
      key_in     = key_ff;
      hold_in    = hold_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data_ff;
      fin        = 1'b0;
      fin_status = 1'b0;
      fin_data   = '0;
      fin_found  = 4'd0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in  = req_value;
               down_in = (req_command == CMD_INSERT);
               case (req_command)
                  CMD_GET: begin
                     if (pos_nonzero && pos_in_list) begin
                        idx_in   = pos_idx;
                        state_in = S_GET_RD;
                     end else begin
                        fin        = 1'b1;
                        fin_status = 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        stop_in  = last_idx;
                        state_in = S_FIND_RD;
                     end else begin
                        fin        = 1'b1;
                        fin_status = 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_nonzero && pos_in_list) begin
                        idx_in   = pos_idx;
                        stop_in  = last_idx;
                        state_in = S_DEL_RD;
                     end else begin
                        fin        = 1'b1;
                        fin_status = 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (pos_nonzero && !list_full && pos_in_ins) begin
                        // walk down from the first free slot to the target
                        idx_in   = IW'(count_ff);
                        stop_in  = pos_idx;
                        state_in = S_MV_RD;
                     end else begin
                        fin        = 1'b1;
                        fin_status = 1'b1;
                     end
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = 1'b1;
                  end
               endcase
            end
         end
         S_GET_RD: begin
            state_in = S_GET_CAP;
         end
         S_GET_CAP: begin
            fin      = 1'b1;
            fin_data = rd_data_ff;
            state_in = S_IDLE;
         end
         S_FIND_RD: begin
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (unit_out.match) begin
               fin       = 1'b1;
               fin_found = 4'(cnt_type'(idx_ff) + cnt_type'(1));
               state_in  = S_IDLE;
            end else if (unit_out.at_stop) begin
               fin        = 1'b1;
               fin_status = 1'b1;
               state_in   = S_IDLE;
            end else begin
               idx_in   = unit_out.nxt;
               state_in = S_FIND_RD;
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            hold_in  = rd_data_ff;
            state_in = S_MV_RD;
         end
         S_MV_RD: begin
            if (unit_out.at_stop) begin
               fin      = 1'b1;
               state_in = S_IDLE;
               if (down_ff) begin
                  // drop the new value into the opened slot
                  wr_en    = 1'b1;
                  wr_data  = key_ff;
                  count_in = count_ff + cnt_type'(1);
               end else begin
                  fin_data = hold_ff;
                  count_in = count_ff - cnt_type'(1);
               end
            end else begin
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            // move the neighbor just read into the current slot, then advance
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = unit_out.nxt;
            state_in = S_MV_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      stop_ff <= stop_in;
      down_ff <= down_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
      if (fin) begin
         rsp_status_ff         <= fin_status;
         rsp_data_out_ff       <= fin_data;
         rsp_found_position_ff <= fin_found;
         rsp_list_length_ff    <= 4'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data_out       = rsp_data_out_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_list_length    = rsp_list_length_ff;

`ifndef NO_ASSERTIONS
   // an accepted beat either starts a walk or answers on the next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither busy nor answered");

   // the length only moves together with a response
   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid)
      else $error("length changed without a response");

   // a reported match is always a success
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_found_position != 4'd0)) |-> !rsp_status)
      else $error("found position with failure status");

   // the length never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("length above capacity");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for positional_list_store: directed and random list commands
// checked against a shadow list kept in the bench. Depends on pls_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import pls_pkg::*;

   localparam int RANDOM_BEATS = 1600;
   localparam int CALM_TAIL    = 200;      // last beats go out back to back
   localparam int DRAIN_CYCLES = 24;       // longer than the slowest command
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] pos;
      word_type   val;
   } list_cmd_t;

   typedef struct {
      logic       status;
      word_type   data;
      logic [3:0] found;
      logic [3:0] len;
   } list_rsp_t;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} list_phase_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_command = CMD_GET;
   logic [7:0]  req_position = '0;
   logic [31:0] req_value = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_status;
   logic [31:0] rsp_data_out;
   logic [3:0]  rsp_found_position;
   logic [3:0]  rsp_list_length;

   list_cmd_t cmd_backlog[$];    // beats not yet offered to the block
   list_rsp_t rsp_expected[$];   // responses owed by the block, oldest first
   list_cmd_t beat_on_wire;

   // shadow copy of the list; only slots below shadow_len are ever read
   word_type shadow_words[DEPTH];
   int       shadow_len = 0;

   int  gap_left = 0;
   bit  calm = 1'b0;
   int  beats_taken = 0;
   int  bad_results = 0;
   int  cycles = 0;

   positional_list_store u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one command to the shadow list and return the response it owes.
   function automatic list_rsp_t apply_to_shadow_list(input list_cmd_t c);
      list_rsp_t r;
      int        p;
      int        i;
      r.status = 1'b1;
      r.data   = '0;
      r.found  = '0;
      p = c.pos;
      case (c.cmd)
         CMD_GET: begin
            if (p >= 1 && p <= shadow_len) begin
               r.status = 1'b0;
               r.data   = shadow_words[p-1];
            end
         end
         CMD_FIND: begin
            // scan from the top so the lowest match wins
            for (i = shadow_len - 1; i >= 0; i--) begin
               if (shadow_words[i] == c.val) begin
                  r.status = 1'b0;
                  r.found  = 4'(i + 1);
               end
            end
         end
         CMD_DELETE: begin
            if (p >= 1 && p <= shadow_len) begin
               r.status = 1'b0;
               r.data   = shadow_words[p-1];
               for (i = p - 1; i < shadow_len - 1; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_len--;
            end
         end
         default: begin
            // insert: reject bad position and full list, else open a slot
            if (p >= 1 && shadow_len < DEPTH && p <= shadow_len + 1) begin
               r.status = 1'b0;
               for (i = shadow_len; i > p - 1; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[p-1] = c.val;
               shadow_len++;
            end
         end
      endcase
      r.len = 4'(shadow_len);
      return r;
   endfunction

   task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] pos, input word_type val);
      list_cmd_t c;
      c.cmd = cmd;
      c.pos = pos;
      c.val = val;
      cmd_backlog.push_back(c);
   endtask

   // Driver: record the beat taken at this edge, then hold, idle or offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            rsp_expected.push_back(apply_to_shadow_list(beat_on_wire));
            beats_taken++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               beat_on_wire = cmd_backlog.pop_front();
               start        <= 1'b1;
               req_command  <= beat_on_wire.cmd;
               req_position <= beat_on_wire.pos;
               req_value    <= beat_on_wire.val;
               // switch between bursty and back-to-back stretches now and then
               if ($urandom_range(0, 39) == 0)
                  calm = ~calm;
               if (!calm && cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 13);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe must match the oldest owed response.
   always @(posedge clock) begin
      list_rsp_t want;
      if (!reset && rsp_valid) begin
         if (rsp_expected.size() == 0) begin
            bad_results++;
            if (bad_results <= REPORT_MAX)
               $display("%0t: response with none owed: status %0b data %h found %0d len %0d",
                        $realtime, rsp_status, rsp_data_out, rsp_found_position,
                        rsp_list_length);
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_status !== want.status || rsp_data_out !== want.data ||
                rsp_found_position !== want.found || rsp_list_length !== want.len) begin
               bad_results++;
               if (bad_results <= REPORT_MAX)
                  $display("%0t: mismatch exp st %0b data %h found %0d len %0d / got st %0b data %h found %0d len %0d",
                           $realtime, want.status, want.data, want.found, want.len,
                           rsp_status, rsp_data_out, rsp_found_position, rsp_list_length);
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** positional_list_store: FAILED **");
         $finish;
      end
   end

   initial begin
      word_type    value_pool[8];
      list_phase_t phase;
      int          n;
      int          roll;
      int          ins_pct;
      int          del_pct;
      logic [1:0]  cmd;
      logic [7:0]  pos;
      word_type    val;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (n = 4; n < 8; n++)
         value_pool[n] = $urandom;

      // empty list: every read, delete and find fails, bad insert positions fail
      queue_cmd(CMD_GET,    8'd1, '0);
      queue_cmd(CMD_DELETE, 8'd1, '0);
      queue_cmd(CMD_FIND,   8'd0, 32'h0000_0000);
      queue_cmd(CMD_INSERT, 8'd0, 32'h1234_5678);
      queue_cmd(CMD_INSERT, 8'd2, 32'h1234_5678);
      // build the list at front, end and middle with extreme values
      queue_cmd(CMD_INSERT, 8'd1, 32'h7FFF_FFFF);
      queue_cmd(CMD_INSERT, 8'd1, 32'h8000_0000);
      queue_cmd(CMD_INSERT, 8'd3, 32'h0000_0000);
      queue_cmd(CMD_INSERT, 8'd2, 32'hFFFF_FFFF);
      queue_cmd(CMD_GET,    8'd1, '0);
      queue_cmd(CMD_GET,    8'd4, '0);
      queue_cmd(CMD_GET,    8'd5, '0);
      queue_cmd(CMD_FIND,   8'd255, 32'hFFFF_FFFF);
      queue_cmd(CMD_FIND,   8'd0, 32'h0001_2345);
      // duplicate value: find must report the first copy
      queue_cmd(CMD_INSERT, 8'd5, 32'hFFFF_FFFF);
      queue_cmd(CMD_FIND,   8'd7, 32'hFFFF_FFFF);
      // fill up, then hit the full list at the end and at the front
      queue_cmd(CMD_INSERT, 8'd1, 32'h0000_0001);
      queue_cmd(CMD_INSERT, 8'd1, 32'h0000_0002);
      queue_cmd(CMD_INSERT, 8'd1, 32'h0000_0003);
      queue_cmd(CMD_INSERT, 8'd9, 32'h0000_0004);
      queue_cmd(CMD_INSERT, 8'd1, 32'h0000_0004);
      queue_cmd(CMD_GET,    8'd8, '0);
      // delete last and first, then out-of-range positions
      queue_cmd(CMD_DELETE, 8'd8, '0);
      queue_cmd(CMD_DELETE, 8'd1, '0);
      queue_cmd(CMD_DELETE, 8'd0, '0);
      queue_cmd(CMD_DELETE, 8'd255, '0);

      // random part: phases that push the list toward full, toward empty, or churn it
      phase = PH_MIX;
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0)
            phase = list_phase_t'($urandom_range(0, 2));
         case (phase)
            PH_FILL: begin
               ins_pct = 60;
               del_pct = 10;
            end
            PH_DRAIN: begin
               ins_pct = 10;
               del_pct = 60;
            end
            default: begin
               ins_pct = 30;
               del_pct = 30;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < ins_pct)
            cmd = CMD_INSERT;
         else if (roll < ins_pct + del_pct)
            cmd = CMD_DELETE;
         else if (roll % 2 == 0)
            cmd = CMD_GET;
         else
            cmd = CMD_FIND;
         // mostly positions near the list, now and then any byte
         if ($urandom_range(0, 6) == 0)
            pos = 8'($urandom_range(0, 255));
         else
            pos = 8'($urandom_range(0, 9));
         // a small pool keeps finds hitting; fully random values cover every bit
         if ($urandom_range(0, 3) == 0)
            val = $urandom;
         else
            val = value_pool[$urandom_range(0, 7)];
         queue_cmd(cmd, pos, val);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // wait for every beat to go out and every response to come back
      @(posedge clock);
      while (cmd_backlog.size() > 0 || start || rsp_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bad_results == 0)
         $display("** positional_list_store: PASSED **");
      else
         $display("** positional_list_store: FAILED **");
      $finish;
   end

endmodule

[files.f]
design/pls_pkg.sv
design/pls_unit.sv
design/positional_list_store.sv
verif/tb.sv
